// File: design/afu_pkg.sv
// afu_pkg: shared types, codes, constants and the 2^u table of the activation unit
// depends on nothing; imported by every design file
`default_nettype none

package afu_pkg;

    localparam int DATA_W     = 24;
    localparam int TAB_DEPTH  = 256;
    localparam int TAB_IDX_W  = 9;
    localparam int QUO_W      = 31;
    localparam int DIV_STAGES = QUO_W;

    typedef logic signed [DATA_W-1:0] t_data;

    localparam t_data DATA_MAX = 24'sh7fffff;
    localparam t_data DATA_MIN = 24'sh800000;

    localparam logic [2:0] KIND_SIGMOID = 3'd0;
    localparam logic [2:0] KIND_ELU     = 3'd1;
    localparam logic [2:0] KIND_SILU    = 3'd2;
    localparam logic [2:0] KIND_TANH    = 3'd3;
    localparam logic [2:0] KIND_RELU    = 3'd4;
    localparam logic [2:0] KIND_LINEAR  = 3'd5;

    localparam logic OP_ACT   = 1'b0;
    localparam logic OP_DERIV = 1'b1;

    localparam logic [31:0] Q30       = 32'h4000_0000;
    localparam logic [31:0] LN2_Q30   = 32'd744261118;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    typedef struct packed {
        logic        opcode;
        t_data       x;
        logic        neg;
        logic [30:0] e;
    } t_side;

    typedef logic [31:0] t_pow2_tab [0:TAB_DEPTH];

    // 2^u on [0,1] in q2.30, truncated taylor series of e^(u ln2)
    function automatic t_pow2_tab build_pow2_tab();
        t_pow2_tab   tab;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i <= TAB_DEPTH; i++) begin
            z    = (64'(i) * 64'(LN2_Q30)) / TAB_DEPTH;
            term = 64'(Q30);
            sum  = term;
            for (int n = 1; n <= 14; n++) begin
                term = ((term * z) >> 30) / 64'(n);
                sum  = sum + term;
            end
            tab[i] = sum[31:0];
        end
        return tab;
    endfunction

    localparam t_pow2_tab POW2_TAB = build_pow2_tab();

    // nonnegative q2.30 to q2.16, round half up
    function automatic logic [17:0] to_q(input logic [31:0] v);
        logic [32:0] sum;
        sum = 33'(v) + 33'h2000;
        return sum[31:14];
    endfunction

endpackage

`default_nettype wire

// File: design/afu_if.sv
// afu_in_if and afu_out_if: valid/ready item channels of the activation unit
// depends on afu_pkg
`default_nettype none

interface afu_in_if import afu_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  opcode;
    t_data x_value;

    modport source (output valid, output opcode, output x_value, input ready);
    modport sink   (input valid, input opcode, input x_value, output ready);
endinterface

interface afu_out_if import afu_pkg::*; ();
    logic  valid;
    logic  ready;
    t_data y_value;
    logic  saturated;

    modport source (output valid, output y_value, output saturated, input ready);
    modport sink   (input valid, input y_value, input saturated, output ready);
endinterface

`default_nettype wire

// File: design/activation_function_unit.sv
// activation_function_unit: top level, function register and the three pipeline parts
// depends on afu_pkg, afu_if, afu_exp, afu_div, afu_post
`default_nettype none

// Evaluates sigmoid, ELU, SiLU, tanh, ReLU or linear (function register, reset linear)
// or its derivative (opcode 1) on a signed Q8.16 value, with saturation to Q8.16.
// One item per cycle is accepted unless a stall backs up to the input; each item passes
// through four front stages (argument, exponent scaling, table interpolation, denominator),
// a 31-stage divider that produces one sigmoid quotient bit per stage, and three
// back stages (product, function select, second product and saturation).
// Every stage carries its own valid bit, so empty stages fill while the output is
// stalled; the function register must only be written while the block is empty.

module activation_function_unit import afu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    afu_in_if.sink     i_item,
    afu_out_if.source  o_result
);

    logic [2:0] r_kind;

    logic        exp_valid, exp_ready;
    logic [31:0] exp_den;
    t_side       exp_side;

    logic             div_valid, div_ready;
    logic [QUO_W-1:0] div_quo;
    t_side            div_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_LINEAR;
        end else if (i_cfg_we) begin
            r_kind <= i_cfg_wdata;
        end
    end

    afu_exp u_exp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_kind   (r_kind),
        .i_valid  (i_item.valid),
        .o_ready  (i_item.ready),
        .i_opcode (i_item.opcode),
        .i_x      (i_item.x_value),
        .o_valid  (exp_valid),
        .i_ready  (exp_ready),
        .o_den    (exp_den),
        .o_side   (exp_side)
    );

    afu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (exp_valid),
        .o_ready (exp_ready),
        .i_den   (exp_den),
        .i_side  (exp_side),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    afu_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_kind  (r_kind),
        .i_valid (div_valid),
        .o_ready (div_ready),
        .i_quo   (div_quo),
        .i_side  (div_side),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_y     (o_result.y_value),
        .o_sat   (o_result.saturated)
    );

endmodule

`default_nettype wire

// File: design/afu_exp.sv
// afu_exp: four-stage front end, argument select, exp via interpolated 2^u table,
// sigmoid denominator; depends on afu_pkg
`default_nettype none

module afu_exp import afu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_kind,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  t_data       i_x,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_den,
    output t_side       o_side
);

    logic [3:0] r_v;
    logic [3:0] en;

    t_side       r_a_side, r_b_side, r_c_side, r_d_side;
    logic [21:0] r_a_m;
    logic        r_a_big, r_b_big, r_c_big;
    logic [22:0] r_b_t;
    logic [31:0] r_c_v;
    logic [6:0]  r_c_k;
    logic [31:0] r_d_den;

    logic signed [24:0] arg;
    logic [24:0]        mag;
    t_side              n_a_side;
    logic [52:0]        prod_t;
    logic [52:0]        sum_t;
    logic [16:0]        g;
    logic [TAB_IDX_W-1:0] idx;
    logic [15:0]        fr;
    logic [31:0]        lo, hi, d, n_c_v;
    logic [47:0]        prod_d;
    logic [7:0]         sh;
    logic [31:0]        e_full;
    logic [30:0]        e;
    t_side              n_d_side;

    always_comb begin
        en[3] = !r_v[3] || i_ready;
        en[2] = !r_v[2] || en[3];
        en[1] = !r_v[1] || en[2];
        en[0] = !r_v[0] || en[1];
    end

    assign o_ready = en[0];
    assign o_valid = r_v[3];
    assign o_den   = r_d_den;
    assign o_side  = r_d_side;

    // stage a: argument, 2x for tanh
    always_comb begin
        arg = (i_kind == KIND_TANH) ? {i_x, 1'b0} : {i_x[DATA_W-1], i_x};
        mag = arg[24] ? 25'(-arg) : 25'(arg);
        n_a_side.opcode = i_opcode;
        n_a_side.x      = i_x;
        n_a_side.neg    = arg[24];
        n_a_side.e      = '0;
    end

    // stage b: t = m * log2(e)
    always_comb begin
        prod_t = 53'(r_a_m) * 53'(LOG2E_Q30);
        sum_t  = prod_t + 53'h2000_0000;
    end

    // stage c: 2^(1-frac) by table interpolation
    always_comb begin
        g      = 17'h10000 - {1'b0, r_b_t[15:0]};
        idx    = g[16:8];
        fr     = {g[7:0], 8'h00};
        lo     = POW2_TAB[idx];
        hi     = g[16] ? POW2_TAB[idx] : POW2_TAB[idx + TAB_IDX_W'(1)];
        d      = (hi > lo) ? hi - lo : 32'd0;
        prod_d = 48'(d) * 48'(fr);
        n_c_v  = g[16] ? POW2_TAB[TAB_DEPTH] : lo + prod_d[47:16];
    end

    // stage d: scale by 2^-(k+1), denominator 1 + e
    always_comb begin
        sh       = {1'b0, r_c_k} + 8'd1;
        e_full   = r_c_v >> sh[5:0];
        e        = (r_c_big || sh >= 8'd64) ? 31'd0 : e_full[30:0];
        n_d_side = r_c_side;
        n_d_side.e = e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            if (en[1]) begin
                r_v[1] <= r_v[0];
            end
            if (en[2]) begin
                r_v[2] <= r_v[1];
            end
            if (en[3]) begin
                r_v[3] <= r_v[2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a_side <= n_a_side;
            r_a_m    <= mag[21:0];
            r_a_big  <= (mag[24:22] != 3'd0);
        end
        if (en[1]) begin
            r_b_side <= r_a_side;
            r_b_big  <= r_a_big;
            r_b_t    <= sum_t[52:30];
        end
        if (en[2]) begin
            r_c_side <= r_b_side;
            r_c_big  <= r_b_big;
            r_c_k    <= r_b_t[22:16];
            r_c_v    <= n_c_v;
        end
        if (en[3]) begin
            r_d_side <= n_d_side;
            r_d_den  <= Q30 + 32'(e);
        end
    end

endmodule

`default_nettype wire

// File: design/afu_div.sv
// afu_div: one quotient bit per stage restoring divider, s = (2^60 + den/2) / den
// depends on afu_pkg
`default_nettype none

module afu_div import afu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [31:0]      i_den,
    input  t_side            i_side,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [QUO_W-1:0] o_quo,
    output t_side            o_side
);

    logic [DIV_STAGES-1:0] r_v;
    logic [DIV_STAGES-1:0] en;
    logic [31:0]           r_den [DIV_STAGES];
    logic [31:0]           r_rem [DIV_STAGES];
    logic [QUO_W-1:0]      r_quo [DIV_STAGES];
    t_side                 r_side [DIV_STAGES];

    logic [31:0]      src_den [DIV_STAGES];
    logic [31:0]      src_rem [DIV_STAGES];
    logic [QUO_W-1:0] src_quo [DIV_STAGES];
    logic [31:0]      shifted [DIV_STAGES];
    logic             ge      [DIV_STAGES];
    logic [31:0]      n_rem   [DIV_STAGES];
    logic [QUO_W-1:0] n_quo   [DIV_STAGES];

    always_comb begin
        en[DIV_STAGES-1] = !r_v[DIV_STAGES-1] || i_ready;
        for (int i = DIV_STAGES - 2; i >= 0; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quo   = r_quo[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

    // low numerator bits are den/2, the part above them reduces to 2^29
    always_comb begin
        for (int i = 0; i < DIV_STAGES; i++) begin
            if (i == 0) begin
                src_den[i] = i_den;
                src_rem[i] = 32'h2000_0000;
                src_quo[i] = '0;
            end else begin
                src_den[i] = r_den[i-1];
                src_rem[i] = r_rem[i-1];
                src_quo[i] = r_quo[i-1];
            end
            shifted[i] = {src_rem[i][30:0], src_den[i][QUO_W-i]};
            ge[i]      = (shifted[i] >= src_den[i]);
            n_rem[i]   = ge[i] ? shifted[i] - src_den[i] : shifted[i];
            n_quo[i]   = {src_quo[i][QUO_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                if (en[i]) begin
                    r_v[i] <= (i == 0) ? i_valid : r_v[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DIV_STAGES; i++) begin
            if (en[i]) begin
                r_den[i]  <= src_den[i];
                r_rem[i]  <= n_rem[i];
                r_quo[i]  <= n_quo[i];
                r_side[i] <= (i == 0) ? i_side : r_side[i-1];
            end
        end
    end

endmodule

`default_nettype wire

// File: design/afu_post.sv
// afu_post: three-stage back end, function select, products, rounding, saturation
// depends on afu_pkg
`default_nettype none

module afu_post import afu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [2:0]       i_kind,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [QUO_W-1:0] i_quo,
    input  t_side            i_side,
    output logic             o_valid,
    input  logic             i_ready,
    output t_data            o_y,
    output logic             o_sat
);

    localparam logic signed [25:0] Y_MAX = 26'sd8388607;
    localparam logic signed [25:0] Y_MIN = -26'sd8388608;
    localparam logic signed [25:0] Y_ONE = 26'sd65536;

    logic [2:0] r_v;
    logic [2:0] en;

    logic [61:0] r_e_prod;
    logic [30:0] r_e_sf;
    logic [30:0] r_e_tm;
    logic        r_e_tneg;
    logic [24:0] r_e_s24;
    t_side       r_e_side;

    logic signed [25:0] r_f_y;
    logic signed [25:0] r_f_inner;
    logic               r_f_sec;
    logic [24:0]        r_f_s24;

    t_data r_g_y;
    logic  r_g_sat;

    logic [30:0]        s, sf, oms;
    logic [31:0]        s24_sum, om24_sum;
    logic [24:0]        s24, om24;
    logic signed [32:0] t;
    logic [30:0]        tm;
    logic [23:0]        ax;
    logic [30:0]        ma, mb;
    logic [61:0]        prod;

    logic signed [25:0] x26;
    logic [17:0]        q;
    logic [47:0]        rsum;
    logic signed [25:0] sr;
    logic signed [25:0] n_f_y;
    logic signed [25:0] n_f_inner;
    logic               n_f_sec;

    logic [24:0]        mi;
    logic [49:0]        p2;
    logic [49:0]        p2_sum;
    logic signed [25:0] yg;
    t_data              n_g_y;
    logic               n_g_sat;

    always_comb begin
        en[2] = !r_v[2] || i_ready;
        en[1] = !r_v[1] || en[2];
        en[0] = !r_v[0] || en[1];
    end

    assign o_ready = en[0];
    assign o_valid = r_v[2];
    assign o_y     = r_g_y;
    assign o_sat   = r_g_sat;

    // stage e: sigmoid fix-up and the first product
    always_comb begin
        s        = (i_quo > Q30[30:0]) ? Q30[30:0] : i_quo;
        sf       = i_side.neg ? Q30[30:0] - s : s;
        oms      = Q30[30:0] - sf;
        s24_sum  = 32'(sf) + 32'd32;
        om24_sum = 32'(oms) + 32'd32;
        s24      = s24_sum[30:6];
        om24     = om24_sum[30:6];
        t        = $signed({1'b0, sf, 1'b0}) - $signed(33'(Q30));
        tm       = t[32] ? 31'(-t) : t[30:0];
        ax       = i_side.x[DATA_W-1] ? 24'(-i_side.x) : 24'(i_side.x);
        case (i_kind)
            KIND_SIGMOID: begin
                ma = sf;
                mb = oms;
            end
            KIND_TANH: begin
                ma = tm;
                mb = tm;
            end
            KIND_SILU: begin
                ma = 31'(ax);
                mb = (i_side.opcode == OP_DERIV) ? 31'(om24) : 31'(s24);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
        prod = 62'(ma) * 62'(mb);
    end

    // stage f: per-function result
    always_comb begin
        x26       = 26'(r_e_side.x);
        rsum      = r_e_prod[47:0] + 48'h80_0000;
        sr        = r_e_side.x[DATA_W-1] ? -$signed({2'b00, rsum[47:24]})
                                         : $signed({2'b00, rsum[47:24]});
        q         = '0;
        n_f_y     = '0;
        n_f_inner = '0;
        n_f_sec   = 1'b0;
        case (i_kind)
            KIND_SIGMOID: begin
                q = (r_e_side.opcode == OP_DERIV) ? to_q(r_e_prod[61:30])
                                                  : to_q({1'b0, r_e_sf});
                n_f_y = $signed({8'b0, q});
            end
            KIND_ELU: begin
                if (!r_e_side.x[DATA_W-1] && r_e_side.x != '0) begin
                    n_f_y = (r_e_side.opcode == OP_DERIV) ? Y_ONE : x26;
                end else if (r_e_side.opcode == OP_DERIV) begin
                    q     = to_q({1'b0, r_e_side.e});
                    n_f_y = $signed({8'b0, q});
                end else begin
                    q     = to_q(Q30 - {1'b0, r_e_side.e});
                    n_f_y = -$signed({8'b0, q});
                end
            end
            KIND_SILU: begin
                n_f_y     = sr;
                n_f_inner = Y_ONE + sr;
                n_f_sec   = (r_e_side.opcode == OP_DERIV);
            end
            KIND_TANH: begin
                if (r_e_side.opcode == OP_DERIV) begin
                    q     = to_q(Q30 - r_e_prod[61:30]);
                    n_f_y = $signed({8'b0, q});
                end else begin
                    q     = to_q({1'b0, r_e_tm});
                    n_f_y = r_e_tneg ? -$signed({8'b0, q}) : $signed({8'b0, q});
                end
            end
            KIND_RELU: begin
                if (r_e_side.x[DATA_W-1]) begin
                    n_f_y = '0;
                end else begin
                    n_f_y = (r_e_side.opcode == OP_DERIV) ? Y_ONE : x26;
                end
            end
            default: begin
                n_f_y = (r_e_side.opcode == OP_DERIV) ? Y_ONE : x26;
            end
        endcase
    end

    // stage g: silu derivative second product, saturation
    always_comb begin
        mi     = r_f_inner[25] ? 25'(-r_f_inner) : r_f_inner[24:0];
        p2     = 50'(mi) * 50'(r_f_s24);
        p2_sum = p2 + 50'h80_0000;
        if (r_f_sec) begin
            yg = r_f_inner[25] ? -$signed(p2_sum[49:24]) : $signed(p2_sum[49:24]);
        end else begin
            yg = r_f_y;
        end
        if (yg > Y_MAX) begin
            n_g_y   = DATA_MAX;
            n_g_sat = 1'b1;
        end else if (yg < Y_MIN) begin
            n_g_y   = DATA_MIN;
            n_g_sat = 1'b1;
        end else begin
            n_g_y   = yg[DATA_W-1:0];
            n_g_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            if (en[1]) begin
                r_v[1] <= r_v[0];
            end
            if (en[2]) begin
                r_v[2] <= r_v[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_e_prod <= prod;
            r_e_sf   <= sf;
            r_e_tm   <= tm;
            r_e_tneg <= t[32];
            r_e_s24  <= s24;
            r_e_side <= i_side;
        end
        if (en[1]) begin
            r_f_y     <= n_f_y;
            r_f_inner <= n_f_inner;
            r_f_sec   <= n_f_sec;
            r_f_s24   <= r_e_s24;
        end
        if (en[2]) begin
            r_g_y   <= n_g_y;
            r_g_sat <= n_g_sat;
        end
    end

endmodule

`default_nettype wire

// File: design/afu_checker.sv
// afu_checker: port-level assertions for the activation unit, bound to the top level
// depends on afu_pkg and activation_function_unit
`default_nettype none

module afu_checker import afu_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_data i_y,
    input logic  i_sat
);

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // clipped results sit on a bound
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sat |-> (i_y == DATA_MAX || i_y == DATA_MIN))
        else $error("saturated result not at a bound");

    // input only backs up behind a stalled result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input not ready without an output stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_y) && $stable(i_sat))
        else $error("stalled result changed");

endmodule

bind activation_function_unit afu_checker u_afu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_y         (o_result.y_value),
    .i_sat       (o_result.saturated)
);

`default_nettype wire
